[hdl/path_oram_access_core_assert.svh]
// ----------------------------------------------------------------------------
// path_oram_access_core assertion macros
// property wrappers sharing the core clock and reset
// ----------------------------------------------------------------------------
`ifndef PATH_ORAM_ACCESS_CORE_ASSERT_SVH
`define PATH_ORAM_ACCESS_CORE_ASSERT_SVH

// same-cycle implication
`define POA_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("poa assertion failed");

// next-cycle implication
`define POA_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("poa assertion failed");

`endif

[hdl/poa_pkg.sv]
// ----------------------------------------------------------------------------
// poa_pkg
// shared types, sizes and controller commands of the path oram access core
// ----------------------------------------------------------------------------
package poa_pkg;

	localparam int TREE_LEVELS = 11;
	localparam int LEAF_W      = TREE_LEVELS - 1;
	localparam int LVL_W       = $clog2(TREE_LEVELS);
	localparam int NODE_W      = TREE_LEVELS;
	localparam int NODE_DEPTH  = 1 << NODE_W;
	localparam int MAX_SLOTS   = 4;
	localparam int SLOT_W      = $clog2(MAX_SLOTS);
	localparam int TAKEN_W     = $clog2(MAX_SLOTS + 1);
	localparam int SLOT_DEPTH  = 1 << (NODE_W + SLOT_W);
	localparam int STASH_DEPTH = 64;
	localparam int STASH_AW    = $clog2(STASH_DEPTH);
	localparam int CNT_W       = STASH_AW + 1;
	localparam int PAY_W       = 64;
	localparam int ID_W        = 10;
	localparam int BLOCK_COUNT = 1024;
	localparam int CFG_W       = 3;
	localparam int CLR_W       = NODE_W;

	typedef struct packed {
		logic             func;
		logic [ID_W-1:0]  block_id;
		logic [PAY_W-1:0] write_word;
		logic [9:0]       fresh_leaf;
	} req_t;

	typedef struct packed {
		logic [PAY_W-1:0] read_word;
		logic             hit;
		logic             overflowed;
		logic [6:0]       stash_fill;
	} rsp_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [PAY_W-1:0] pay;
	} entry_t;

	typedef enum logic [3:0] {
		OP_NOP, OP_CLEAR, OP_ACCEPT, OP_REMAP, OP_ROW_RD, OP_SLOT_RD, OP_SLOT_PUSH,
		OP_HS_RD, OP_HS_CHK, OP_UPDATE, OP_EV_START, OP_EV_RD, OP_EV_POS, OP_EV_DEC,
		OP_EV_ROW, OP_DONE
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic slot_last;
		logic lvl_last;
		logic lvl_zero;
		logic idx_lt_cnt;
		logic match;
		logic out_free;
		logic ovf;
	} sts_t;

	// register value 0 acts as 1, above the slot count acts as the slot count
	function automatic logic [TAKEN_W-1:0] clamp_k(input logic [CFG_W-1:0] v);
		logic [TAKEN_W-1:0] r;
		if (v == '0) begin
			r = TAKEN_W'(1);
		end else if (v > CFG_W'(MAX_SLOTS)) begin
			r = TAKEN_W'(MAX_SLOTS);
		end else begin
			r = TAKEN_W'(v);
		end
		return r;
	endfunction

endpackage

[hdl/poa_ram.sv]
// ----------------------------------------------------------------------------
// poa_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module poa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[hdl/poa_ctrl.sv]
// ----------------------------------------------------------------------------
// poa_ctrl
// access sequencer: clearing pass, path read, stash search, eviction
// ----------------------------------------------------------------------------
module poa_ctrl import poa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  sts_t sts,
	output cmd_t cmd
);
	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_REMAP, S_ROW_RD, S_SLOT_RD, S_SLOT_PUSH, S_HS_RD, S_HS_CHK,
		S_UPDATE, S_EV_START, S_EV_RD, S_EV_POS, S_EV_DEC, S_EV_ROW, S_DONE
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			unique case (state_q)
				S_CLEAR:     if (sts.clr_last) state_q <= S_IDLE;
				S_IDLE:      if (req_valid) state_q <= S_REMAP;
				S_REMAP:     state_q <= S_ROW_RD;
				S_ROW_RD:    state_q <= S_SLOT_RD;
				S_SLOT_RD:   state_q <= S_SLOT_PUSH;
				S_SLOT_PUSH: begin
					if (!sts.slot_last) state_q <= S_SLOT_RD;
					else if (sts.lvl_last) state_q <= S_HS_RD;
					else state_q <= S_ROW_RD;
				end
				S_HS_RD:     state_q <= sts.idx_lt_cnt ? S_HS_CHK : S_UPDATE;
				S_HS_CHK:    state_q <= sts.match ? S_UPDATE : S_HS_RD;
				S_UPDATE:    state_q <= S_EV_START;
				S_EV_START:  state_q <= S_EV_RD;
				S_EV_RD:     state_q <= sts.idx_lt_cnt ? S_EV_POS : S_EV_ROW;
				S_EV_POS:    state_q <= S_EV_DEC;
				S_EV_DEC:    state_q <= S_EV_RD;
				S_EV_ROW:    state_q <= sts.lvl_zero ? S_DONE : S_EV_START;
				S_DONE:      if (sts.out_free) state_q <= S_IDLE;
				default:     state_q <= S_CLEAR;
			endcase
		end
	end

	always_comb begin
		req_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_CLEAR:     cmd.op = OP_CLEAR;
			S_IDLE:      cmd.op = req_valid ? OP_ACCEPT : OP_NOP;
			S_REMAP:     cmd.op = OP_REMAP;
			S_ROW_RD:    cmd.op = OP_ROW_RD;
			S_SLOT_RD:   cmd.op = OP_SLOT_RD;
			S_SLOT_PUSH: cmd.op = OP_SLOT_PUSH;
			S_HS_RD:     cmd.op = OP_HS_RD;
			S_HS_CHK:    cmd.op = OP_HS_CHK;
			S_UPDATE:    cmd.op = OP_UPDATE;
			S_EV_START:  cmd.op = OP_EV_START;
			S_EV_RD:     cmd.op = OP_EV_RD;
			S_EV_POS:    cmd.op = OP_EV_POS;
			S_EV_DEC:    cmd.op = OP_EV_DEC;
			S_EV_ROW:    cmd.op = OP_EV_ROW;
			S_DONE:      cmd.op = sts.out_free ? OP_DONE : OP_NOP;
			default:     cmd.op = OP_NOP;
		endcase
	end
endmodule

[hdl/poa_dp.sv]
// ----------------------------------------------------------------------------
// poa_dp
// datapath: position map, tree and stash memories, counters, result register
// ----------------------------------------------------------------------------
module poa_dp import poa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  req_t             req,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp
);
	localparam int POS_AW = $clog2(BLOCK_COUNT);

	// control state
	logic [CFG_W-1:0]    k_q;
	logic [CLR_W-1:0]    clr_q;
	logic [LVL_W-1:0]    lvl_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [CNT_W-1:0]    idx_q, cnt_q, kept_q;
	logic [TAKEN_W-1:0]  taken_q;
	logic                hit_q, ovf_q, rsp_valid_q;
	// payload state
	req_t                req_q;
	logic [LEAF_W-1:0]   old_leaf_q;
	logic [PAY_W-1:0]    rdata_q;
	rsp_t                rsp_q;

	// memory ports
	logic                pos_we, pos_re, vrow_we, vrow_re, slot_we, slot_re, st_we, st_re;
	logic [POS_AW-1:0]   pos_waddr, pos_raddr;
	logic [LEAF_W-1:0]   pos_wdata, pos_rdata;
	logic [NODE_W-1:0]   vrow_waddr;
	logic [MAX_SLOTS-1:0] vrow_wdata, vrow_rdata;
	logic [NODE_W+SLOT_W-1:0] slot_waddr, slot_raddr;
	entry_t              slot_rdata, st_wdata, st_rdata;
	logic [STASH_AW-1:0] st_waddr;

	logic [LVL_W-1:0]    sh;
	logic [NODE_W-1:0]   node;
	logic                ev_take, push_full, row_bit;
	logic [TAKEN_W-1:0]  k_eff;
	logic [MAX_SLOTS:0]  take_mask;

	always_comb begin
		sh        = LVL_W'(LEAF_W) - lvl_q;
		node      = (NODE_W'(1) << lvl_q) - NODE_W'(1) + NODE_W'(old_leaf_q >> sh);
		k_eff     = clamp_k(k_q);
		ev_take   = (taken_q < k_eff) && ((pos_rdata >> sh) == (old_leaf_q >> sh));
		push_full = (cnt_q >= CNT_W'(STASH_DEPTH));
		row_bit   = vrow_rdata[slot_q];
		take_mask = ((MAX_SLOTS+1)'(1) << taken_q) - (MAX_SLOTS+1)'(1);
	end

	// memory port steering
	always_comb begin
		pos_we    = 1'b0;
		pos_waddr = req_q.block_id[POS_AW-1:0];
		pos_wdata = req_q.fresh_leaf[LEAF_W-1:0];
		pos_re    = 1'b0;
		pos_raddr = req.block_id[POS_AW-1:0];
		vrow_we    = 1'b0;
		vrow_waddr = node;
		vrow_wdata = take_mask[MAX_SLOTS-1:0];
		vrow_re    = (cmd.op == OP_ROW_RD);
		slot_re    = (cmd.op == OP_SLOT_RD);
		slot_raddr = {node, slot_q};
		slot_we    = 1'b0;
		slot_waddr = {node, taken_q[SLOT_W-1:0]};
		st_re      = (cmd.op == OP_HS_RD) || (cmd.op == OP_EV_RD);
		st_we      = 1'b0;
		st_waddr   = cnt_q[STASH_AW-1:0];
		st_wdata   = slot_rdata;
		case (cmd.op)
			OP_CLEAR: begin
				pos_we     = !clr_q[CLR_W-1];
				pos_waddr  = clr_q[POS_AW-1:0];
				pos_wdata  = '0;
				vrow_we    = 1'b1;
				vrow_waddr = clr_q[NODE_W-1:0];
				vrow_wdata = '0;
			end
			OP_ACCEPT: pos_re = 1'b1;
			OP_REMAP:  pos_we = 1'b1;
			OP_SLOT_PUSH: st_we = row_bit && !push_full;
			OP_UPDATE: begin
				st_wdata = '{id: req_q.block_id, pay: req_q.write_word};
				if (hit_q) begin
					st_waddr = idx_q[STASH_AW-1:0];
					st_we    = req_q.func;
				end else begin
					st_we    = req_q.func && !push_full;
				end
			end
			OP_EV_POS: begin
				pos_re    = 1'b1;
				pos_raddr = st_rdata.id[POS_AW-1:0];
			end
			OP_EV_DEC: begin
				st_wdata = st_rdata;
				slot_we  = ev_take;
				st_we    = !ev_take;
				st_waddr = kept_q[STASH_AW-1:0];
			end
			OP_EV_ROW: vrow_we = 1'b1;
			default: ;
		endcase
	end

	poa_ram #(.WIDTH(LEAF_W), .DEPTH(BLOCK_COUNT)) u_pos (
		.clk, .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
		.re(pos_re), .raddr(pos_raddr), .rdata(pos_rdata)
	);
	poa_ram #(.WIDTH(MAX_SLOTS), .DEPTH(NODE_DEPTH)) u_vrow (
		.clk, .we(vrow_we), .waddr(vrow_waddr), .wdata(vrow_wdata),
		.re(vrow_re), .raddr(node), .rdata(vrow_rdata)
	);
	poa_ram #(.WIDTH($bits(entry_t)), .DEPTH(SLOT_DEPTH)) u_slot (
		.clk, .we(slot_we), .waddr(slot_waddr), .wdata(st_rdata),
		.re(slot_re), .raddr(slot_raddr), .rdata(slot_rdata)
	);
	poa_ram #(.WIDTH($bits(entry_t)), .DEPTH(STASH_DEPTH)) u_stash (
		.clk, .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
		.re(st_re), .raddr(idx_q[STASH_AW-1:0]), .rdata(st_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= CFG_W'(MAX_SLOTS);
			clr_q       <= '0;
			lvl_q       <= '0;
			slot_q      <= '0;
			idx_q       <= '0;
			cnt_q       <= '0;
			kept_q      <= '0;
			taken_q     <= '0;
			hit_q       <= 1'b0;
			ovf_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				k_q <= cfg_wdata;
			end
			if (cmd.op == OP_DONE) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (cmd.op)
				OP_CLEAR:  clr_q <= clr_q + 1'b1;
				OP_ACCEPT: hit_q <= 1'b0;
				OP_REMAP: begin
					lvl_q  <= '0;
					slot_q <= '0;
					idx_q  <= '0;
				end
				OP_SLOT_PUSH: begin
					slot_q <= slot_q + 1'b1;
					if (slot_q == SLOT_W'(MAX_SLOTS - 1)) begin
						lvl_q <= lvl_q + 1'b1;
					end
					if (row_bit) begin
						if (push_full) ovf_q <= 1'b1;
						else cnt_q <= cnt_q + 1'b1;
					end
				end
				OP_HS_CHK: begin
					if (st_rdata.id == req_q.block_id) hit_q <= 1'b1;
					else idx_q <= idx_q + 1'b1;
				end
				OP_UPDATE: begin
					lvl_q <= LVL_W'(TREE_LEVELS - 1);
					if (req_q.func && !hit_q) begin
						if (push_full) ovf_q <= 1'b1;
						else cnt_q <= cnt_q + 1'b1;
					end
				end
				OP_EV_START: begin
					idx_q   <= '0;
					kept_q  <= '0;
					taken_q <= '0;
				end
				OP_EV_DEC: begin
					idx_q <= idx_q + 1'b1;
					if (ev_take) taken_q <= taken_q + 1'b1;
					else kept_q <= kept_q + 1'b1;
				end
				OP_EV_ROW: begin
					cnt_q <= kept_q;
					if (lvl_q != '0) lvl_q <= lvl_q - 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_ACCEPT) begin
			req_q   <= req;
			rdata_q <= '0;
		end
		if (cmd.op == OP_REMAP) begin
			old_leaf_q <= pos_rdata;
		end
		if (cmd.op == OP_UPDATE && hit_q && !req_q.func) begin
			rdata_q <= st_rdata.pay;
		end
		if (cmd.op == OP_DONE) begin
			rsp_q <= '{read_word: rdata_q, hit: hit_q, overflowed: ovf_q,
				stash_fill: cnt_q};
		end
	end

	always_comb begin
		sts.clr_last   = (clr_q == '1);
		sts.slot_last  = (slot_q == SLOT_W'(MAX_SLOTS - 1));
		sts.lvl_last   = (lvl_q == LVL_W'(TREE_LEVELS - 1));
		sts.lvl_zero   = (lvl_q == '0);
		sts.idx_lt_cnt = (idx_q < cnt_q);
		sts.match      = (st_rdata.id == req_q.block_id);
		sts.out_free   = !rsp_valid_q || rsp_ready;
		sts.ovf        = ovf_q;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
endmodule

[hdl/path_oram_access_core.sv]
// throughput: one access at a time, bounded by the stash scans in eviction
// reset: arst_n clears control state, then a clearing pass zeroes the position map
// and the bucket valid rows; no request is taken during the pass
// the configuration register resets to four slots per bucket
// ----------------------------------------------------------------------------
// path_oram_access_core
// path oram access controller: remap, path read into the stash, stash lookup
// and update, greedy leaf-to-root eviction
// ----------------------------------------------------------------------------
`include "path_oram_access_core_assert.svh"

module path_oram_access_core import poa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// request channel, one beat per access
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req,
	// result channel, one beat per access
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp,
	// slots-per-bucket register
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);
	cmd_t cmd;
	sts_t sts;

	// sequencer owns the order of steps; the datapath owns every store
	poa_ctrl u_ctrl (
		.clk, .arst_n, .req_valid, .req_ready, .sts, .cmd
	);

	// position map, bucket rows, slots and stash, with the result register
	poa_dp u_dp (
		.clk, .arst_n, .cmd, .sts, .req, .cfg_we, .cfg_wdata,
		.rsp_valid, .rsp_ready, .rsp
	);

	// stash occupancy never passes its depth
	`POA_ASSERT_NOW(a_fill_bound, rsp_valid, rsp.stash_fill <= CNT_W'(STASH_DEPTH))
	// one access in flight: the request side closes after a beat
	`POA_ASSERT_NEXT(a_single_access, req_valid && req_ready, !req_ready)
	// overflow flag is sticky
	`POA_ASSERT_NEXT(a_ovf_sticky, sts.ovf, sts.ovf)
	// no request taken during the clearing pass
	`POA_ASSERT_NOW(a_clear_blocks, cmd.op == OP_CLEAR, !req_ready)
endmodule
